/* design/qta_pkg.sv */
// qta_pkg: shared widths, default parameter values and opcodes of the quadtree tile allocator
// no dependencies; used by the top level and its checker
`timescale 1ns / 1ps

package qta_pkg;

   localparam int SIZE_W            = 16;
   localparam int TILE_W            = 12;
   localparam int GSIZE_W           = 13;
   localparam int MAP_LOG2_DEF      = 12;
   localparam int MIN_TILE_LOG2_DEF = 7;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_CLEAR = 1'b1
   } opcode_type;

endpackage

/* design/quadtree_tile_allocator_top.sv */
// quadtree_tile_allocator_top: quadtree tile allocator, sequencer around one free-flag ram
// depends on qta_pkg and qta_ram
`timescale 1ns / 1ps

// Usage
//   Items enter on start with req_opcode and req_tile_size; one is taken at a clock edge where
//   start is high and busy is low. Each item gives exactly one result, shown on the rsp_ ports
//   for one cycle while rsp_valid is high; the receiver cannot stall it.
//   Allocate: the size is clamped, then ceil log2 is found by stepping one bit position per
//   cycle. The depth-first search then reads each node of the free-flag ram in an address
//   state and a check state, and passes an advance state for each level climbed back up.
//   The single ram port is why each node read takes both an address and a check state.
//   Clear: the ram is swept one node per cycle over all NUM_NODES nodes (1365 at default
//   settings), then a result with all fields zero is given.
//   Reset: synchronous, active high. After reset the same clearing sweep runs with busy high
//   and gives no result; then the block is idle.
//   The result register is separate from the sequencer, so busy drops in the cycle the result
//   is shown and a new item may be taken there.
module quadtree_tile_allocator_top #(
   parameter int MAP_LOG2      = qta_pkg::MAP_LOG2_DEF,
   parameter int MIN_TILE_LOG2 = qta_pkg::MIN_TILE_LOG2_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       req_opcode,
   input  logic [qta_pkg::SIZE_W-1:0] req_tile_size,
   output logic                       busy,
   output logic                       rsp_valid,
   output logic                       rsp_granted,
   output logic [qta_pkg::TILE_W-1:0] rsp_tile_x,
   output logic [qta_pkg::TILE_W-1:0] rsp_tile_y,
   output logic [qta_pkg::GSIZE_W-1:0] rsp_granted_size
);

   import qta_pkg::*;

   localparam int EFF_MIN = (MIN_TILE_LOG2 < MAP_LOG2) ? MIN_TILE_LOG2 : MAP_LOG2;
   localparam int NUM_LEVELS = MAP_LOG2 - EFF_MIN + 1;
   localparam longint NUM_NODES = ((64'd1 << (2 * NUM_LEVELS)) - 64'd1) / 64'd3;
   localparam int ADDR_W = (NUM_NODES > 4) ? $clog2(NUM_NODES) : 2;
   localparam int LVL_W = $clog2(MAP_LOG2 + 1);
   localparam int XY_W = MAP_LOG2;
   localparam int EDGE_W = MAP_LOG2 + 1;
   localparam int SHIFT_W = SIZE_W + 1;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_NODES - 64'd1);
   localparam logic [SIZE_W-1:0] MIN_EDGE = SIZE_W'(64'd1 << EFF_MIN);
   localparam logic [SIZE_W-1:0] MAX_EDGE = SIZE_W'(64'd1 << MAP_LOG2);
   localparam logic [EDGE_W-1:0] ROOT_EDGE = {1'b1, {MAP_LOG2{1'b0}}};

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SIZE,
      ST_READ,
      ST_CHECK,
      ST_ADVANCE
   } state_type;

   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  idx_ff, idx_in;
   logic [LVL_W-1:0]   level_ff, level_in;
   logic [LVL_W-1:0]   req_ff, req_in;
   logic [LVL_W-1:0]   k_ff, k_in;
   logic [XY_W-1:0]    x_ff, x_in;
   logic [XY_W-1:0]    y_ff, y_in;
   logic [EDGE_W-1:0]  edge_ff, edge_in;
   logic [SIZE_W-1:0]  size_ff, size_in;
   logic               clr_rsp_ff, clr_rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_granted_ff, rsp_granted_in;
   logic [TILE_W-1:0]  rsp_x_ff, rsp_x_in;
   logic [TILE_W-1:0]  rsp_y_ff, rsp_y_in;
   logic [GSIZE_W-1:0] rsp_size_ff, rsp_size_in;

   logic              ram_we;
   logic              ram_wdata;
   logic              ram_rdata;
   logic [1:0]        quad;
   logic              do_adv;
   logic [XY_W-1:0]   step;

   // children of node n sit at 4n+1 .. 4n+4
   assign quad = idx_ff[1:0] - 2'd1;
   assign step = XY_W'(edge_ff);

   qta_ram #(
      .WIDTH (1),
      .DEPTH (int'(NUM_NODES)),
      .ADDR_W(ADDR_W)
   ) u_ram (
      .clock(clock),
      .we   (ram_we),
      .addr (idx_ff),
      .wdata(ram_wdata),
      .rdata(ram_rdata)
   );

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      level_in       = level_ff;
      req_in         = req_ff;
      k_in           = k_ff;
      x_in           = x_ff;
      y_in           = y_ff;
      edge_in        = edge_ff;
      size_in        = size_ff;
      clr_rsp_in     = clr_rsp_ff;
      rsp_valid_in   = 1'b0;
      rsp_granted_in = rsp_granted_ff;
      rsp_x_in       = rsp_x_ff;
      rsp_y_in       = rsp_y_ff;
      rsp_size_in    = rsp_size_ff;
      ram_we         = 1'b0;
      ram_wdata      = 1'b1;
      do_adv         = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            if (idx_ff == LAST_ADDR) begin
               state_in   = ST_IDLE;
               clr_rsp_in = 1'b0;
               if (clr_rsp_ff) begin
                  rsp_valid_in   = 1'b1;
                  rsp_granted_in = 1'b0;
                  rsp_x_in       = '0;
                  rsp_y_in       = '0;
                  rsp_size_in    = '0;
               end
            end else begin
               idx_in = idx_ff + ADDR_W'(1);
            end
         end
         ST_IDLE: begin
            if (start) begin
               if (req_opcode == OP_CLEAR) begin
                  state_in   = ST_CLEAR;
                  idx_in     = '0;
                  clr_rsp_in = 1'b1;
               end else begin
                  priority if (req_tile_size < MIN_EDGE) begin
                     size_in = MIN_EDGE;
                  end else if (req_tile_size > MAX_EDGE) begin
                     size_in = MAX_EDGE;
                  end else begin
                     size_in = req_tile_size;
                  end
                  k_in     = LVL_W'(EFF_MIN);
                  state_in = ST_SIZE;
               end
            end
         end
         ST_SIZE: begin
            // ceil log2, one bit position per cycle
            if ((SHIFT_W'(1) << k_ff) < {1'b0, size_ff}) begin
               k_in = k_ff + LVL_W'(1);
            end else begin
               req_in   = LVL_W'(MAP_LOG2) - k_ff;
               idx_in   = '0;
               level_in = '0;
               x_in     = '0;
               y_in     = '0;
               edge_in  = ROOT_EDGE;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (ram_rdata) begin
               if (level_ff == req_ff) begin
                  ram_we         = 1'b1;
                  ram_wdata      = 1'b0;
                  rsp_valid_in   = 1'b1;
                  rsp_granted_in = 1'b1;
                  rsp_x_in       = TILE_W'(x_ff);
                  rsp_y_in       = TILE_W'(y_ff);
                  rsp_size_in    = GSIZE_W'(edge_ff);
                  state_in       = ST_IDLE;
               end else begin
                  idx_in   = (idx_ff << 2) | ADDR_W'(1);
                  level_in = level_ff + LVL_W'(1);
                  edge_in  = edge_ff >> 1;
                  state_in = ST_READ;
               end
            end else begin
               do_adv = 1'b1;
            end
         end
         ST_ADVANCE: begin
            do_adv = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // move to the next sibling, climbing while the current node is the last child; at the root, refuse the item
      if (do_adv) begin
         priority if (level_ff == '0) begin
            rsp_valid_in   = 1'b1;
            rsp_granted_in = 1'b0;
            rsp_x_in       = '0;
            rsp_y_in       = '0;
            rsp_size_in    = '0;
            state_in       = ST_IDLE;
         end else if (quad != 2'd3) begin
            idx_in   = idx_ff + ADDR_W'(1);
            state_in = ST_READ;
            if (quad == 2'd1) begin
               x_in = x_ff - step;
               y_in = y_ff + step;
            end else begin
               x_in = x_ff + step;
            end
         end else begin
            idx_in   = (idx_ff >> 2) - ADDR_W'(1);
            x_in     = x_ff - step;
            y_in     = y_ff - step;
            edge_in  = edge_ff << 1;
            level_in = level_ff - LVL_W'(1);
            state_in = ST_ADVANCE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         clr_rsp_ff   <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      level_ff       <= level_in;
      req_ff         <= req_in;
      k_ff           <= k_in;
      x_ff           <= x_in;
      y_ff           <= y_in;
      edge_ff        <= edge_in;
      size_ff        <= size_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_x_ff       <= rsp_x_in;
      rsp_y_ff       <= rsp_y_in;
      rsp_size_ff    <= rsp_size_in;
   end

   assign busy             = reset || (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_granted      = rsp_granted_ff;
   assign rsp_tile_x       = rsp_x_ff;
   assign rsp_tile_y       = rsp_y_ff;
   assign rsp_granted_size = rsp_size_ff;

endmodule

/* design/qta_ram.sv */
// qta_ram: generic single-address ram, one read and an optional write a cycle, registered read data
// no dependencies
`timescale 1ns / 1ps

module qta_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4,
   parameter int ADDR_W = (DEPTH > 4) ? $clog2(DEPTH) : 2
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] addr,
   input  logic [WIDTH-1:0]  wdata,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end

endmodule

/* design/qta_checker.sv */
// qta_checker: port-level assertions for the quadtree tile allocator, bound to the top level
// depends on qta_pkg and quadtree_tile_allocator_top
`timescale 1ns / 1ps

module qta_checker #(
   parameter int MAP_LOG2 = qta_pkg::MAP_LOG2_DEF
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic                        rsp_valid,
   input logic                        rsp_granted,
   input logic [qta_pkg::TILE_W-1:0]  rsp_tile_x,
   input logic [qta_pkg::TILE_W-1:0]  rsp_tile_y,
   input logic [qta_pkg::GSIZE_W-1:0] rsp_granted_size
);

   import qta_pkg::*;

   localparam bit SIZE_FITS = (MAP_LOG2 <= TILE_W);

   logic [GSIZE_W-1:0] size_mask;
   assign size_mask = rsp_granted_size - GSIZE_W'(1);

   // an accepted item always makes the sequencer busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("item accepted but busy did not rise");

   // every result closes a busy period
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a preceding busy cycle");

   // results are single-cycle strobes, never back to back
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two results in consecutive cycles");

   a_nogrant_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_granted) |->
         (rsp_tile_x == '0 && rsp_tile_y == '0 && rsp_granted_size == '0))
      else $error("refused item with nonzero tile fields");

   // granted tiles are power-of-two squares aligned to their own size (checked when MAP_LOG2 fits TILE_W)
   a_grant_aligned: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_granted && SIZE_FITS) |->
         ($onehot(rsp_granted_size) &&
          (({1'b0, rsp_tile_x} & size_mask) == '0) &&
          (({1'b0, rsp_tile_y} & size_mask) == '0)))
      else $error("granted tile not aligned or size not a power of two");

endmodule

bind quadtree_tile_allocator_top qta_checker #(
   .MAP_LOG2(MAP_LOG2)
) u_qta_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_granted     (rsp_granted),
   .rsp_tile_x      (rsp_tile_x),
   .rsp_tile_y      (rsp_tile_y),
   .rsp_granted_size(rsp_granted_size)
);
